// File: src/ppcc_pkg.sv
// shared types and constants for the pixel pair color converter
`timescale 1ns / 1ps

package ppcc_pkg;

  localparam int NumBytes = 8;
  localparam int NumSums  = 6;
  localparam int SumW     = 20;
  localparam int QuotW    = 12;

  typedef enum logic [2:0] {
    MODE_RGB_UYVY  = 3'd0,
    MODE_BGRA_YUVA = 3'd1,
    MODE_UYVY_RGB  = 3'd2,
    MODE_UYVY_YUV  = 3'd3,
    MODE_YUV_UYVY  = 3'd4,
    MODE_COPY      = 3'd5
  } mode_e;

  typedef logic [NumBytes-1:0][7:0] bytes_t;
  typedef logic [SumW-1:0] sum_t;
  typedef sum_t [NumSums-1:0] sums_t;

  typedef struct packed {
    logic  vld;
    mode_e mode;
  } ctrl_t;

  // bt.601 coefficients, rgb to yuv
  localparam logic signed [SumW-1:0] KYR = 20'sd66;
  localparam logic signed [SumW-1:0] KYG = 20'sd129;
  localparam logic signed [SumW-1:0] KYB = 20'sd25;
  localparam logic signed [SumW-1:0] KUV = 20'sd112;
  localparam logic signed [SumW-1:0] KUG = 20'sd74;
  localparam logic signed [SumW-1:0] KUR = 20'sd37;
  localparam logic signed [SumW-1:0] KVG = 20'sd94;
  localparam logic signed [SumW-1:0] KVB = 20'sd18;
  // yuv to rgb
  localparam logic signed [SumW-1:0] KY  = 20'sd298;
  localparam logic signed [SumW-1:0] KRV = 20'sd409;
  localparam logic signed [SumW-1:0] KGU = 20'sd100;
  localparam logic signed [SumW-1:0] KGV = 20'sd208;
  localparam logic signed [SumW-1:0] KBU = 20'sd516;

  localparam logic signed [QuotW-1:0] OffY  = 12'sd16;
  localparam logic signed [QuotW-1:0] OffC  = 12'sd128;
  localparam logic signed [QuotW-1:0] OffR  = -12'sd223;
  localparam logic signed [QuotW-1:0] OffG  = 12'sd135;
  localparam logic signed [QuotW-1:0] OffB  = -12'sd277;

endpackage

// File: src/ppcc_sum_stage.sv
// weighted sum stage: per pixel coefficient sums, registered
`timescale 1ns / 1ps

module ppcc_sum_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ppcc_pkg::ctrl_t   ctrl_i,
  input  ppcc_pkg::bytes_t  bytes_i,
  output logic              ready_o,
  output ppcc_pkg::ctrl_t   ctrl_o,
  output ppcc_pkg::bytes_t  bytes_o,
  output ppcc_pkg::sums_t   sums_o,
  input  logic              ready_i
);

  logic             vld_q;
  ppcc_pkg::mode_e  mode_q;
  ppcc_pkg::bytes_t bytes_q;
  ppcc_pkg::sums_t  sums_q, sums_d;

  logic [7:0] r0, g0, b0, r1, g1, b1;
  logic signed [ppcc_pkg::SumW-1:0] sr0, sg0, sb0, sr1, sg1, sb1;
  logic signed [ppcc_pkg::SumW-1:0] sy0, sy1, su, sv;

  function automatic logic signed [ppcc_pkg::SumW-1:0] zx(logic [7:0] x);
    return $signed({{(ppcc_pkg::SumW-8){1'b0}}, x});
  endfunction

  assign ready_o = !vld_q || ready_i;

  always_comb begin
    case (ctrl_i.mode)
      ppcc_pkg::MODE_BGRA_YUVA: begin
        b0 = bytes_i[0]; g0 = bytes_i[1]; r0 = bytes_i[2];
        b1 = bytes_i[4]; g1 = bytes_i[5]; r1 = bytes_i[6];
      end
      default: begin
        r0 = bytes_i[0]; g0 = bytes_i[1]; b0 = bytes_i[2];
        r1 = bytes_i[3]; g1 = bytes_i[4]; b1 = bytes_i[5];
      end
    endcase
  end

  assign sr0 = zx(r0);
  assign sg0 = zx(g0);
  assign sb0 = zx(b0);
  assign sr1 = zx(r1);
  assign sg1 = zx(g1);
  assign sb1 = zx(b1);
  // uyvy source: u y0 v y1
  assign su  = zx(bytes_i[0]);
  assign sy0 = zx(bytes_i[1]);
  assign sv  = zx(bytes_i[2]);
  assign sy1 = zx(bytes_i[3]);

  always_comb begin
    if (ctrl_i.mode == ppcc_pkg::MODE_UYVY_RGB) begin
      sums_d[0] = ppcc_pkg::KY * sy0 + ppcc_pkg::KRV * sv;
      sums_d[1] = ppcc_pkg::KY * sy0 - ppcc_pkg::KGU * su - ppcc_pkg::KGV * sv;
      sums_d[2] = ppcc_pkg::KY * sy0 + ppcc_pkg::KBU * su;
      sums_d[3] = ppcc_pkg::KY * sy1 + ppcc_pkg::KRV * sv;
      sums_d[4] = ppcc_pkg::KY * sy1 - ppcc_pkg::KGU * su - ppcc_pkg::KGV * sv;
      sums_d[5] = ppcc_pkg::KY * sy1 + ppcc_pkg::KBU * su;
    end else begin
      sums_d[0] = ppcc_pkg::KYR * sr0 + ppcc_pkg::KYG * sg0 + ppcc_pkg::KYB * sb0;
      sums_d[1] = ppcc_pkg::KUV * sb0 - ppcc_pkg::KUG * sg0 - ppcc_pkg::KUR * sr0;
      sums_d[2] = ppcc_pkg::KUV * sr0 - ppcc_pkg::KVG * sg0 - ppcc_pkg::KVB * sb0;
      sums_d[3] = ppcc_pkg::KYR * sr1 + ppcc_pkg::KYG * sg1 + ppcc_pkg::KYB * sb1;
      sums_d[4] = ppcc_pkg::KUV * sb1 - ppcc_pkg::KUG * sg1 - ppcc_pkg::KUR * sr1;
      sums_d[5] = ppcc_pkg::KUV * sr1 - ppcc_pkg::KVG * sg1 - ppcc_pkg::KVB * sb1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ctrl_i.vld) begin
      mode_q  <= ctrl_i.mode;
      bytes_q <= bytes_i;
      sums_q  <= sums_d;
    end
  end

  assign ctrl_o.vld  = vld_q;
  assign ctrl_o.mode = mode_q;
  assign bytes_o     = bytes_q;
  assign sums_o      = sums_q;

endmodule

// File: src/ppcc_pack_stage.sv
// output stage: scale, offset, saturate, average and pack the target bytes
`timescale 1ns / 1ps

module ppcc_pack_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ppcc_pkg::ctrl_t   ctrl_i,
  input  ppcc_pkg::bytes_t  bytes_i,
  input  ppcc_pkg::sums_t   sums_i,
  output logic              ready_o,
  output logic              valid_o,
  output ppcc_pkg::bytes_t  bytes_o,
  input  logic              ready_i
);

  logic             vld_q;
  ppcc_pkg::bytes_t bytes_q, bytes_d;
  logic signed [ppcc_pkg::QuotW-1:0] q [ppcc_pkg::NumSums];
  logic signed [ppcc_pkg::QuotW-1:0] u_sum, v_sum;
  logic [8:0] u_raw, v_raw;

  // divide by 256, rounding toward zero
  function automatic logic signed [ppcc_pkg::QuotW-1:0] div256(
    logic signed [ppcc_pkg::SumW-1:0] x
  );
    logic signed [ppcc_pkg::SumW-1:0] t;
    t = x[ppcc_pkg::SumW-1] ? (x + 20'sd255) : x;
    return ppcc_pkg::QuotW'(t >>> 8);
  endfunction

  function automatic logic [7:0] sat8(logic signed [ppcc_pkg::QuotW-1:0] x);
    logic [7:0] r;
    if (x <= 0) r = 8'd0;
    else if (x > 12'sd255) r = 8'd255;
    else r = x[7:0];
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < ppcc_pkg::NumSums; k++) begin
      q[k] = div256($signed(sums_i[k]));
    end
  end

  assign u_sum = (ppcc_pkg::OffC + q[1]) + (ppcc_pkg::OffC + q[4]);
  assign v_sum = (ppcc_pkg::OffC + q[2]) + (ppcc_pkg::OffC + q[5]);
  assign u_raw = {1'b0, bytes_i[1]} + {1'b0, bytes_i[4]};
  assign v_raw = {1'b0, bytes_i[2]} + {1'b0, bytes_i[5]};

  always_comb begin
    bytes_d = '0;
    case (ctrl_i.mode)
      ppcc_pkg::MODE_RGB_UYVY: begin
        bytes_d[0] = u_sum[8:1];
        bytes_d[1] = 8'(ppcc_pkg::OffY + q[0]);
        bytes_d[2] = v_sum[8:1];
        bytes_d[3] = 8'(ppcc_pkg::OffY + q[3]);
      end
      ppcc_pkg::MODE_BGRA_YUVA: begin
        bytes_d[0] = 8'(ppcc_pkg::OffY + q[0]);
        bytes_d[1] = 8'(ppcc_pkg::OffC + q[1]);
        bytes_d[2] = 8'(ppcc_pkg::OffC + q[2]);
        bytes_d[3] = bytes_i[3];
        bytes_d[4] = 8'(ppcc_pkg::OffY + q[3]);
        bytes_d[5] = 8'(ppcc_pkg::OffC + q[4]);
        bytes_d[6] = 8'(ppcc_pkg::OffC + q[5]);
        bytes_d[7] = bytes_i[7];
      end
      ppcc_pkg::MODE_UYVY_RGB: begin
        bytes_d[0] = sat8(q[0] + ppcc_pkg::OffR);
        bytes_d[1] = sat8(q[1] + ppcc_pkg::OffG);
        bytes_d[2] = sat8(q[2] + ppcc_pkg::OffB);
        bytes_d[3] = sat8(q[3] + ppcc_pkg::OffR);
        bytes_d[4] = sat8(q[4] + ppcc_pkg::OffG);
        bytes_d[5] = sat8(q[5] + ppcc_pkg::OffB);
      end
      ppcc_pkg::MODE_UYVY_YUV: begin
        bytes_d[0] = bytes_i[1];
        bytes_d[1] = bytes_i[0];
        bytes_d[2] = bytes_i[2];
        bytes_d[3] = bytes_i[3];
        bytes_d[4] = bytes_i[0];
        bytes_d[5] = bytes_i[2];
      end
      ppcc_pkg::MODE_YUV_UYVY: begin
        bytes_d[0] = u_raw[8:1];
        bytes_d[1] = bytes_i[0];
        bytes_d[2] = v_raw[8:1];
        bytes_d[3] = bytes_i[3];
      end
      ppcc_pkg::MODE_COPY: begin
        bytes_d = bytes_i;
      end
      default: begin
        bytes_d = '0;
      end
    endcase
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ctrl_i.vld) begin
      bytes_q <= bytes_d;
    end
  end

  assign valid_o = vld_q;
  assign bytes_o = bytes_q;

endmodule

// File: src/pixel_pair_color_converter_core.sv
// Pixel pair color converter: usage
//   One item is the eight bytes of two adjacent pixels in the source layout,
//   on in_byte0_i..in_byte7_i with in_valid_i / in_ready_o. The converted pair
//   leaves on out_byte0_o..out_byte7_o with out_valid_o / out_ready_i.
//   cfg_conversion_mode_i, written with cfg_valid_i (cfg_ready_o is always
//   high), picks the conversion: 0 rgb-uyvy, 1 bgra-yuva, 2 uyvy-rgb,
//   3 uyvy-yuv, 4 yuv-uyvy, 5 copy; 6 and 7 give all-zero items. Change it
//   only while no item is in flight.
//   An accepted item is loaded into the input register at the accepting edge,
//   then into the coefficient sum register and the output register, which
//   drives out_valid_o. Throughput is one item per cycle; each stage takes a
//   new item whenever it is empty or its content moves on in the same cycle.
//   Reset clears all valid bits and sets the mode to copy.
//   When the receiver holds out_ready_i low the pipeline fills up and
//   in_ready_o drops after the three stages hold items; nothing is lost.
`timescale 1ns / 1ps

module pixel_pair_color_converter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_conversion_mode_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte0_i,
  input  logic [7:0] in_byte1_i,
  input  logic [7:0] in_byte2_i,
  input  logic [7:0] in_byte3_i,
  input  logic [7:0] in_byte4_i,
  input  logic [7:0] in_byte5_i,
  input  logic [7:0] in_byte6_i,
  input  logic [7:0] in_byte7_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte0_o,
  output logic [7:0] out_byte1_o,
  output logic [7:0] out_byte2_o,
  output logic [7:0] out_byte3_o,
  output logic [7:0] out_byte4_o,
  output logic [7:0] out_byte5_o,
  output logic [7:0] out_byte6_o,
  output logic [7:0] out_byte7_o
);

  ppcc_pkg::mode_e  mode_q;
  logic             a_vld_q;
  ppcc_pkg::mode_e  a_mode_q;
  ppcc_pkg::bytes_t a_bytes_q, in_bytes;
  ppcc_pkg::ctrl_t  a_ctrl, b_ctrl;
  ppcc_pkg::bytes_t b_bytes, c_bytes;
  ppcc_pkg::sums_t  b_sums;
  logic             b_ready, c_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ppcc_pkg::MODE_COPY;
    end else if (cfg_valid_i) begin
      mode_q <= ppcc_pkg::mode_e'(cfg_conversion_mode_i);
    end
  end

  assign in_bytes = {in_byte7_i, in_byte6_i, in_byte5_i, in_byte4_i,
                     in_byte3_i, in_byte2_i, in_byte1_i, in_byte0_i};

  // input register
  assign in_ready_o = !a_vld_q || b_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_bytes_q <= in_bytes;
      a_mode_q  <= mode_q;
    end
  end

  assign a_ctrl.vld  = a_vld_q;
  assign a_ctrl.mode = a_mode_q;

  ppcc_sum_stage u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (a_ctrl),
    .bytes_i (a_bytes_q),
    .ready_o (b_ready),
    .ctrl_o  (b_ctrl),
    .bytes_o (b_bytes),
    .sums_o  (b_sums),
    .ready_i (c_ready)
  );

  ppcc_pack_stage u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (b_ctrl),
    .bytes_i (b_bytes),
    .sums_i  (b_sums),
    .ready_o (c_ready),
    .valid_o (out_valid_o),
    .bytes_o (c_bytes),
    .ready_i (out_ready_i)
  );

  assign out_byte0_o = c_bytes[0];
  assign out_byte1_o = c_bytes[1];
  assign out_byte2_o = c_bytes[2];
  assign out_byte3_o = c_bytes[3];
  assign out_byte4_o = c_bytes[4];
  assign out_byte5_o = c_bytes[5];
  assign out_byte6_o = c_bytes[6];
  assign out_byte7_o = c_bytes[7];

endmodule

// File: sim/tb_pixel_pair_color_converter_core.sv
// testbench for the pixel pair color converter core: directed table, then random phases
`timescale 1ns / 1ps

module tb_pixel_pair_color_converter_core;

  localparam int PipeDepth     = 3;
  localparam int PhaseCount    = 12;
  localparam int ItemsPerPhase = 125;
  localparam int CycleLimit    = 200_000;
  localparam logic [2:0] MODE_UNDEF_6 = 3'd6;
  localparam logic [2:0] MODE_UNDEF_7 = 3'd7;

  typedef struct {
    logic [2:0]       mode;
    ppcc_pkg::bytes_t px;
    bit               typed;
    ppcc_pkg::bytes_t want;
  } stim_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [2:0]       cfg_mode = ppcc_pkg::MODE_COPY;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  ppcc_pkg::bytes_t in_pair = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  ppcc_pkg::bytes_t out_pair;

  logic [2:0]       mode_now;
  ppcc_pkg::bytes_t pending_pairs[$];
  stim_row_t        dir_rows[$];
  int               err_cnt = 0;
  int               cycle_cnt = 0;
  int               src_gap_max = 8;
  int               sink_stall_max = 8;
  int               stall_left = 0;
  int               gap;
  int               style;
  logic [2:0]       phase_mode;
  ppcc_pkg::bytes_t px;
  ppcc_pkg::bytes_t want;
  ppcc_pkg::bytes_t exp_pair;

  pixel_pair_color_converter_core dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_conversion_mode_i (cfg_mode),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .in_byte0_i            (in_pair[0]),
    .in_byte1_i            (in_pair[1]),
    .in_byte2_i            (in_pair[2]),
    .in_byte3_i            (in_pair[3]),
    .in_byte4_i            (in_pair[4]),
    .in_byte5_i            (in_pair[5]),
    .in_byte6_i            (in_pair[6]),
    .in_byte7_i            (in_pair[7]),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .out_byte0_o           (out_pair[0]),
    .out_byte1_o           (out_pair[1]),
    .out_byte2_o           (out_pair[2]),
    .out_byte3_o           (out_pair[3]),
    .out_byte4_o           (out_pair[4]),
    .out_byte5_o           (out_pair[5]),
    .out_byte6_o           (out_pair[6]),
    .out_byte7_o           (out_pair[7])
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // bt.601 helpers, division truncates toward zero
  function automatic int luma_of(int r, int g, int b);
    return 16 + (66 * r + 129 * g + 25 * b) / 256;
  endfunction

  function automatic int cb_of(int r, int g, int b);
    return 128 + (112 * b - 74 * g - 37 * r) / 256;
  endfunction

  function automatic int cr_of(int r, int g, int b);
    return 128 + (112 * r - 94 * g - 18 * b) / 256;
  endfunction

  function automatic logic [7:0] clip8(int x);
    if (x <= 0) return 8'd0;
    if (x > 255) return 8'd255;
    return x[7:0];
  endfunction

  function automatic ppcc_pkg::bytes_t convert_pair(logic [2:0] mode, ppcc_pkg::bytes_t src);
    ppcc_pkg::bytes_t q;
    int     c[8];
    int     k;
    int     su;
    int     sv;
    int     y;
    q = '0;
    for (k = 0; k < 8; k++) c[k] = int'(src[k]);
    case (mode)
      ppcc_pkg::MODE_RGB_UYVY: begin
        // chroma is the floor average of both pixels
        su = cb_of(c[0], c[1], c[2]) + cb_of(c[3], c[4], c[5]);
        sv = cr_of(c[0], c[1], c[2]) + cr_of(c[3], c[4], c[5]);
        q[0] = 8'(su >>> 1);
        q[1] = 8'(luma_of(c[0], c[1], c[2]));
        q[2] = 8'(sv >>> 1);
        q[3] = 8'(luma_of(c[3], c[4], c[5]));
      end
      ppcc_pkg::MODE_BGRA_YUVA: begin
        for (k = 0; k < 8; k += 4) begin
          q[k]     = 8'(luma_of(c[k+2], c[k+1], c[k]));
          q[k + 1] = 8'(cb_of(c[k+2], c[k+1], c[k]));
          q[k + 2] = 8'(cr_of(c[k+2], c[k+1], c[k]));
          q[k + 3] = src[k+3];
        end
      end
      ppcc_pkg::MODE_UYVY_RGB: begin
        for (k = 0; k < 2; k++) begin
          y = c[1 + 2 * k];
          q[3 * k]     = clip8((298 * y + 409 * c[2]) / 256 - 223);
          q[3 * k + 1] = clip8((298 * y - 100 * c[0] - 208 * c[2]) / 256 + 135);
          q[3 * k + 2] = clip8((298 * y + 516 * c[0]) / 256 - 277);
        end
      end
      ppcc_pkg::MODE_UYVY_YUV: begin
        q[0] = src[1];
        q[1] = src[0];
        q[2] = src[2];
        q[3] = src[3];
        q[4] = src[0];
        q[5] = src[2];
      end
      ppcc_pkg::MODE_YUV_UYVY: begin
        q[0] = 8'((c[1] + c[4]) >>> 1);
        q[1] = src[0];
        q[2] = 8'((c[2] + c[5]) >>> 1);
        q[3] = src[3];
      end
      ppcc_pkg::MODE_COPY: q = src;
      default: q = '0;
    endcase
    return q;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_row(logic [2:0] mode, ppcc_pkg::bytes_t src, bit typed,
                         ppcc_pkg::bytes_t res);
    stim_row_t r;
    r.mode  = mode;
    r.px    = src;
    r.typed = typed;
    r.want  = res;
    dir_rows.push_back(r);
  endtask

  // called in the time step of the previous acceptance, or later
  task automatic push_pair(ppcc_pkg::bytes_t src, ppcc_pkg::bytes_t res, int wait_cycles);
    if (wait_cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (wait_cycles) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_pair    <= src;
    do @(posedge clk_i); while (!in_ready_o);
    pending_pairs.push_back(res);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  task automatic write_mode(logic [2:0] mode);
    cfg_valid_i <= 1'b1;
    cfg_mode    <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_now = mode;
  endtask

  // receiver: random stall before each item, checks against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_pairs.size() == 0) begin
          $display("%0t: unexpected item %h", $time, out_pair);
          err_cnt++;
        end else begin
          exp_pair = pending_pairs.pop_front();
          for (int k = 0; k < 8; k++) begin
            if (out_pair[k] !== exp_pair[k]) begin
              $display("%0t: out_byte%0d expected %02h actual %02h", $time, k, exp_pair[k],
                       out_pair[k]);
              err_cnt++;
            end
          end
        end
        stall_left = $urandom_range(0, sink_stall_max);
        if (stall_left > 0) begin
          out_ready_i <= 1'b0;
          stall_left--;
        end
      end else if (!out_ready_i) begin
        if (stall_left == 0) out_ready_i <= 1'b1;
        else stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("pixel_pair_color_converter_core test failed");
      $finish;
    end
  end

  initial begin
    mode_now = ppcc_pkg::MODE_COPY;
    // extremes with results read straight off the formulas; the rest predicted
    add_row(ppcc_pkg::MODE_COPY, 64'h8040_2010_0804_0201, 1'b1, 64'h8040_2010_0804_0201);
    add_row(ppcc_pkg::MODE_COPY, 64'hffff_ffff_ffff_ffff, 1'b1, 64'hffff_ffff_ffff_ffff);
    add_row(ppcc_pkg::MODE_COPY, 64'h0, 1'b1, 64'h0);
    add_row(ppcc_pkg::MODE_RGB_UYVY, 64'h0, 1'b1, 64'h0000_0000_1080_1080);
    add_row(ppcc_pkg::MODE_RGB_UYVY, 64'hffff_ffff_ffff_ffff, 1'b1, 64'h0000_0000_eb80_eb80);
    add_row(ppcc_pkg::MODE_RGB_UYVY, 64'h5aa5_ff00_0000_00ff, 1'b0, '0);
    // pure green drives the chroma numerators negative
    add_row(ppcc_pkg::MODE_RGB_UYVY, 64'h0000_00ff_0000_ff00, 1'b0, '0);
    add_row(ppcc_pkg::MODE_BGRA_YUVA, 64'h0, 1'b1, 64'h0080_8010_0080_8010);
    add_row(ppcc_pkg::MODE_BGRA_YUVA, 64'hffff_ffff_ffff_ffff, 1'b1, 64'hff80_80eb_ff80_80eb);
    add_row(ppcc_pkg::MODE_BGRA_YUVA, 64'h7f10_e080_01ff_3c9a, 1'b0, '0);
    add_row(ppcc_pkg::MODE_UYVY_RGB, 64'h0, 1'b1, 64'h0000_0087_0000_8700);
    add_row(ppcc_pkg::MODE_UYVY_RGB, 64'hffff_ffff_ffff_ffff, 1'b1, 64'h0000_ff7e_ffff_7eff);
    add_row(ppcc_pkg::MODE_UYVY_RGB, 64'hffff_ffff_1000_ff00, 1'b0, '0);
    add_row(ppcc_pkg::MODE_UYVY_RGB, 64'h0000_0000_eb00_80ff, 1'b0, '0);
    add_row(ppcc_pkg::MODE_UYVY_YUV, 64'h8040_2010_0804_0201, 1'b0, '0);
    add_row(ppcc_pkg::MODE_UYVY_YUV, 64'hffff_ffff_ffff_ffff, 1'b1, 64'h0000_ffff_ffff_ffff);
    add_row(ppcc_pkg::MODE_YUV_UYVY, 64'h0, 1'b1, 64'h0);
    add_row(ppcc_pkg::MODE_YUV_UYVY, 64'hffff_ffff_ffff_ffff, 1'b1, 64'h0000_0000_ffff_ffff);
    // odd chroma sum rounds down
    add_row(ppcc_pkg::MODE_YUV_UYVY, 64'hcdab_fe02_44ff_0133, 1'b0, '0);
    add_row(MODE_UNDEF_6, 64'hffff_ffff_ffff_ffff, 1'b1, 64'h0);
    add_row(MODE_UNDEF_7, 64'hffff_ffff_ffff_ffff, 1'b1, 64'h0);
    add_row(ppcc_pkg::MODE_COPY, 64'h0123_4567_89ab_cdef, 1'b0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != mode_now) begin
        wait_drained();
        write_mode(dir_rows[i].mode);
      end
      want = dir_rows[i].typed ? dir_rows[i].want : convert_pair(mode_now, dir_rows[i].px);
      push_pair(dir_rows[i].px, want, $urandom_range(0, 8));
    end

    for (int p = 0; p < PhaseCount; p++) begin
      // each of the eight mode values once in a fixed order, then random picks
      case (p)
        0: phase_mode = ppcc_pkg::MODE_RGB_UYVY;
        1: phase_mode = MODE_UNDEF_7;
        2: phase_mode = ppcc_pkg::MODE_BGRA_YUVA;
        3: phase_mode = ppcc_pkg::MODE_UYVY_RGB;
        4: phase_mode = ppcc_pkg::MODE_UYVY_YUV;
        5: phase_mode = ppcc_pkg::MODE_YUV_UYVY;
        6: phase_mode = MODE_UNDEF_6;
        7: phase_mode = ppcc_pkg::MODE_COPY;
        default: phase_mode = 3'($urandom_range(0, 7));
      endcase
      wait_drained();
      write_mode(phase_mode);
      style = $urandom_range(0, 3);
      src_gap_max    = style[0] ? 8 : 0;
      sink_stall_max = style[1] ? 8 : 0;
      for (int i = 0; i < ItemsPerPhase; i++) begin
        // hold the sender until the pipeline has emptied
        if (i == ItemsPerPhase / 2 || $urandom_range(0, 99) == 0) wait_drained();
        for (int k = 0; k < 8; k++) px[k] = rand_byte();
        gap = $urandom_range(0, src_gap_max);
        push_pair(px, convert_pair(mode_now, px), gap);
      end
    end

    wait_drained();
    if (err_cnt == 0) begin
      $display("pixel_pair_color_converter_core test passed");
    end else begin
      $display("pixel_pair_color_converter_core test failed");
    end
    $finish;
  end

endmodule
